>>> src/aes128_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, round constants and the byte substitution function.
// ----------------------------------------------------------------------------
`default_nettype none
package aes128_pkg;

   localparam int NumRounds = 10;

   typedef logic [127:0] block_type;
   typedef logic [7:0]   byte_type;

   function automatic byte_type sbox(input byte_type a);
      byte_type r;
      case (a)
         8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
         8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
         8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
         8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
         8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
         8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
         8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
         8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
         8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
         8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
         8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
         8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
         8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
         8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
         8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
         8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
         8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
         8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
         8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
         8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
         8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
         8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
         8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
         8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
         8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
         8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
         8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
         8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
         8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
         8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
         8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
         8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
         8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
         8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
         8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
         8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
         8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
         8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
         8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
         8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
         8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
         8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
         8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
         8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
         8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
         8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
         8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
         8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
         8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
         8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
         8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
         8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
         8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
         8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
         8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
         8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
         8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
         8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
         8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
         8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
         8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
         8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
         8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
         8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // Multiply by x in GF(2^8), reduction polynomial 0x11b.
   function automatic byte_type xtime(input byte_type v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // Round constant for round r (1..10).
   function automatic byte_type rcon(input logic [3:0] r);
      byte_type c;
      case (r)
         4'd1: c = 8'h01; 4'd2: c = 8'h02; 4'd3: c = 8'h04; 4'd4: c = 8'h08;
         4'd5: c = 8'h10; 4'd6: c = 8'h20; 4'd7: c = 8'h40; 4'd8: c = 8'h80;
         4'd9: c = 8'h1b; 4'd10: c = 8'h36;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

>>> src/aes128_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption core
// Fully unrolled pipeline that encrypts one 128-bit block per cycle.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Handshake
//   request   req_plain_low/high, req_key_low/high    start & !busy
//   response  rsp_cipher_low/high                     rsp_valid (one cycle)
//
// A block is taken in every cycle; busy is always low. The pipeline has one
// stage for the initial AddRoundKey and one stage for each of the ten rounds,
// each stage holding its own round key so that the key may change with every
// block. The response cannot be held off, so the pipeline never stalls. Reset
// clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module aes128_block_encrypt_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [63:0] req_plain_low,
   input  wire  [63:0] req_plain_high,
   input  wire  [63:0] req_key_low,
   input  wire  [63:0] req_key_high,
   output logic        rsp_valid,
   output logic [63:0] rsp_cipher_low,
   output logic [63:0] rsp_cipher_high
);

   localparam int Stages = aes128_pkg::NumRounds + 1;

   // Stage 0 registers the whitened block and the cipher key.
   logic                  valid0_ff;
   aes128_pkg::block_type state0_ff;
   aes128_pkg::block_type key0_ff;

   logic                  valid_w [Stages];
   aes128_pkg::block_type state_w [Stages];
   aes128_pkg::block_type key_w   [Stages];

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else begin
         valid0_ff <= start;
      end
      state0_ff <= {req_plain_high, req_plain_low} ^ {req_key_high, req_key_low};
      key0_ff   <= {req_key_high, req_key_low};
   end

   assign valid_w[0] = valid0_ff;
   assign state_w[0] = state0_ff;
   assign key_w[0]   = key0_ff;

   // One registered round per stage; round numbers are fixed at elaboration.
   for (genvar g = 1; g < Stages; g++) begin : g_round
      aes128_round u_round (
         .clock     (clock),
         .reset     (reset),
         .round_num (4'(g)),
         .valid_in  (valid_w[g-1]),
         .state_in  (state_w[g-1]),
         .key_in    (key_w[g-1]),
         .valid_out (valid_w[g]),
         .state_out (state_w[g]),
         .key_out   (key_w[g])
      );
   end

   assign rsp_valid       = valid_w[Stages-1];
   assign rsp_cipher_low  = state_w[Stages-1][63:0];
   assign rsp_cipher_high = state_w[Stages-1][127:64];

endmodule
`default_nettype wire

>>> src/aes128_round.sv
// ----------------------------------------------------------------------------
// AES-128 round stage
// One registered round: SubBytes, ShiftRows, optional MixColumns, key step.
// ----------------------------------------------------------------------------
`default_nettype none
module aes128_round (
   input  wire                      clock,
   input  wire                      reset,
   input  wire  [3:0]               round_num,
   input  wire                      valid_in,
   input  aes128_pkg::block_type    state_in,
   input  aes128_pkg::block_type    key_in,
   output logic                     valid_out,
   output aes128_pkg::block_type    state_out,
   output aes128_pkg::block_type    key_out
);

   aes128_pkg::block_type sub_shift;
   aes128_pkg::block_type mixed;
   aes128_pkg::block_type key_next;
   aes128_pkg::block_type state_ff, state_in_nxt;
   aes128_pkg::block_type key_ff;
   logic                  valid_ff;

   // Byte r+4c sits at bits 8(r+4c)+7..8(r+4c).
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sub_shift[8*(r+4*c) +: 8] =
               aes128_pkg::sbox(state_in[8*(r+4*((c+r)%4)) +: 8]);
         end
      end
   end

   always_comb begin
      aes128_pkg::byte_type a0, a1, a2, a3, all;
      for (int c = 0; c < 4; c++) begin
         a0 = sub_shift[32*c +: 8];
         a1 = sub_shift[32*c+8 +: 8];
         a2 = sub_shift[32*c+16 +: 8];
         a3 = sub_shift[32*c+24 +: 8];
         all = a0 ^ a1 ^ a2 ^ a3;
         mixed[32*c +: 8]    = a0 ^ all ^ aes128_pkg::xtime(a0 ^ a1);
         mixed[32*c+8 +: 8]  = a1 ^ all ^ aes128_pkg::xtime(a1 ^ a2);
         mixed[32*c+16 +: 8] = a2 ^ all ^ aes128_pkg::xtime(a2 ^ a3);
         mixed[32*c+24 +: 8] = a3 ^ all ^ aes128_pkg::xtime(a3 ^ a0);
      end
   end

   always_comb begin
      logic [31:0] t;
      t = {aes128_pkg::sbox(key_in[103:96]), aes128_pkg::sbox(key_in[127:120]),
           aes128_pkg::sbox(key_in[119:112]),
           aes128_pkg::sbox(key_in[111:104]) ^ aes128_pkg::rcon(round_num)};
      for (int w = 0; w < 4; w++) begin
         t = t ^ key_in[32*w +: 32];
         key_next[32*w +: 32] = t;
      end
   end

   assign state_in_nxt =
      ((round_num == 4'(aes128_pkg::NumRounds)) ? sub_shift : mixed) ^ key_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      state_ff <= state_in_nxt;
      key_ff   <= key_next;
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;

endmodule
`default_nettype wire

>>> src/aes128_checker.sv
// ----------------------------------------------------------------------------
// AES-128 core port checker
// Watches the core's ports for latency and idle behaviour.
// ----------------------------------------------------------------------------
`default_nettype none
module aes128_core_checker (
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire rsp_valid
);

   // Every beat taken returns a response once it has passed the stage 0 and round registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##11 rsp_valid)
      else $error("response missing after accepted beat");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 11))
      else $error("response without matching request");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("core raised busy");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response during reset");

endmodule

bind aes128_block_encrypt_core aes128_core_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
`default_nettype wire
